// ===== design/pva_pkg.sv =====
// shared types, constants and the pitch table for the voice allocator
// no dependencies; imported by every module of the block
package pva_pkg;

	// voice count, fixed for the whole block and its result format
	localparam int VOICES = 8;
	localparam int VOICE_W = $clog2(VOICES);
	localparam int CNT_W = $clog2(VOICES + 1);
	localparam int NOTE_W = 7;
	localparam int TIME_W = 32;
	localparam int PITCH_W = 16;
	localparam int NOTE_COUNT = 128;

	// pitch scaling: round((note - 69) * 32768 / 120), halves away from zero
	localparam int NOTE_REF = 69;
	localparam int PITCH_SCALE = 32768;
	localparam int PITCH_DEN = 120;
	localparam int PITCH_HALF = 60;

	// lowest-note search starts above any note
	localparam int LOW_W = 8;
	localparam int LOW_INIT = 255;

	typedef enum logic {
		FUNC_NOTE_ON  = 1'b0,
		FUNC_NOTE_OFF = 1'b1
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [NOTE_W-1:0]  note_number;
		logic [TIME_W-1:0]  event_time;
	} in_beat_t;

	typedef struct packed {
		logic [VOICE_W-1:0]        voice;
		logic signed [PITCH_W-1:0] pitch_cv;
		logic                      gate;
		logic                      last;
	} out_beat_t;

	typedef struct packed {
		logic               held;
		logic [NOTE_W-1:0]  note;
		logic [TIME_W-1:0]  stamp;
	} tbl_entry_t;

	typedef struct packed {
		logic               en_a;
		logic               en_b;
		logic               held;
		logic [NOTE_W-1:0]  note;
		logic [TIME_W-1:0]  stamp;
	} tbl_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ON_PUT,
		ST_OFF_FLUSH
	} ctl_state_t;

	typedef logic signed [PITCH_W-1:0] pitch_lut_t [NOTE_COUNT];

	function automatic pitch_lut_t build_pitch_lut();
		pitch_lut_t lut;
		int i;
		int d;
		int q;
		for (i = 0; i < NOTE_COUNT; i++) begin
			d = i - NOTE_REF;
			if (d >= 0) begin
				q = (d * PITCH_SCALE + PITCH_HALF) / PITCH_DEN;
			end else begin
				q = -(((-d) * PITCH_SCALE + PITCH_HALF) / PITCH_DEN);
			end
			lut[i] = PITCH_W'(q);
		end
		return lut;
	endfunction

	localparam pitch_lut_t PITCH_LUT = build_pitch_lut();

endpackage

// ===== design/pva_table.sv =====
// voice table: held/note memory and release stamp memory, registered read
// depends on pva_pkg; valid bits make never-written entries read as reset
module pva_table import pva_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [VOICE_W-1:0] rd_addr,
	input  logic [VOICE_W-1:0] wr_addr,
	input  tbl_wr_t            wr,
	output tbl_entry_t         rd_data
);

	logic [NOTE_W:0]    mem_a [VOICES];
	logic [TIME_W-1:0]  mem_b [VOICES];
	logic [VOICES-1:0]  va_q;
	logic [VOICES-1:0]  vb_q;
	logic [NOTE_W:0]    a_s1;
	logic [TIME_W-1:0]  b_s1;
	logic               va_s1;
	logic               vb_s1;

	always_ff @(posedge clk) begin
		if (wr.en_a) begin
			mem_a[wr_addr] <= {wr.held, wr.note};
		end
		if (wr.en_b) begin
			mem_b[wr_addr] <= wr.stamp;
		end
		if (rd_en) begin
			a_s1 <= mem_a[rd_addr];
			b_s1 <= mem_b[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q  <= '0;
			vb_q  <= '0;
			va_s1 <= 1'b0;
			vb_s1 <= 1'b0;
		end else begin
			if (wr.en_a) begin
				va_q[wr_addr] <= 1'b1;
			end
			if (wr.en_b) begin
				vb_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				va_s1 <= va_q[rd_addr];
				vb_s1 <= vb_q[rd_addr];
			end
		end
	end

	// unwritten entries read as free, note 0, stamp 0
	always_comb begin
		rd_data.held  = va_s1 & a_s1[NOTE_W];
		rd_data.note  = va_s1 ? a_s1[NOTE_W-1:0] : '0;
		rd_data.stamp = vb_s1 ? b_s1 : '0;
	end

endmodule

// ===== design/pva_ctrl.sv =====
// event sequencer: sweeps the voice table once per event, picks or releases
// voices and writes back; depends on pva_pkg, drives pva_table
module pva_ctrl import pva_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               evt_valid,
	output logic               evt_stall,
	input  in_beat_t           evt,
	input  logic               can_push,
	output logic               push,
	output out_beat_t          push_beat,
	output logic               tbl_rd_en,
	output logic [VOICE_W-1:0] tbl_rd_addr,
	output logic [VOICE_W-1:0] tbl_wr_addr,
	output tbl_wr_t            tbl_wr,
	input  tbl_entry_t         tbl_rd_data
);

	ctl_state_t          state_q;
	ctl_state_t          state_d;
	func_t               func_q;
	logic [NOTE_W-1:0]   note_q;
	logic [TIME_W-1:0]   time_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic                s1_vld_q;
	logic [VOICE_W-1:0]  s1_idx_q;
	logic                found_q;
	logic [TIME_W-1:0]   best_q;
	logic [VOICE_W-1:0]  free_pick_q;
	logic [LOW_W-1:0]    low_q;
	logic [VOICE_W-1:0]  steal_pick_q;
	logic                pend_vld_q;
	logic [VOICE_W-1:0]  pend_idx_q;

	logic               accept;
	logic               reads_left;
	logic               match;
	logic               hold;
	logic               advance;
	logic               issue;
	logic               scan_done;
	logic               is_on;
	logic               free_take;
	logic               steal_take;
	logic [VOICE_W-1:0] pick;

	always_comb begin
		accept     = evt_valid && (state_q == ST_IDLE);
		reads_left = rd_idx_q < CNT_W'(VOICES);
		is_on      = (func_q == FUNC_NOTE_ON);
		match      = s1_vld_q && !is_on && tbl_rd_data.held &&
			(tbl_rd_data.note == note_q);
		// a second match must wait until the earlier one can leave
		hold       = match && pend_vld_q && !can_push;
		advance    = (state_q == ST_SCAN) && !hold;
		issue      = advance && reads_left;
		scan_done  = (state_q == ST_SCAN) && !reads_left && !s1_vld_q;
		free_take  = s1_vld_q && is_on && !tbl_rd_data.held &&
			(!found_q || (tbl_rd_data.stamp < best_q));
		steal_take = s1_vld_q && is_on && ({1'b0, tbl_rd_data.note} <= low_q);
		pick       = found_q ? free_pick_q : steal_pick_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (evt_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = is_on ? ST_ON_PUT : ST_OFF_FLUSH;
				end
			end
			ST_ON_PUT: begin
				if (can_push) begin
					state_d = ST_IDLE;
				end
			end
			ST_OFF_FLUSH: begin
				if (!pend_vld_q || can_push) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		evt_stall          = (state_q != ST_IDLE);
		tbl_rd_en          = issue;
		tbl_rd_addr        = rd_idx_q[VOICE_W-1:0];
		tbl_wr_addr        = s1_idx_q;
		tbl_wr             = '0;
		push               = 1'b0;
		push_beat.voice    = pend_idx_q;
		push_beat.pitch_cv = '0;
		push_beat.gate     = 1'b0;
		push_beat.last     = 1'b0;
		case (state_q)
			ST_SCAN: begin
				if (advance && match) begin
					tbl_wr.en_a  = 1'b1;
					tbl_wr.en_b  = 1'b1;
					tbl_wr.held  = 1'b0;
					tbl_wr.note  = tbl_rd_data.note;
					tbl_wr.stamp = time_q;
					push         = pend_vld_q;
				end
			end
			ST_ON_PUT: begin
				tbl_wr_addr = pick;
				if (can_push) begin
					tbl_wr.en_a        = 1'b1;
					tbl_wr.held        = 1'b1;
					tbl_wr.note        = note_q;
					push               = 1'b1;
					push_beat.voice    = pick;
					push_beat.pitch_cv = PITCH_LUT[note_q];
					push_beat.gate     = 1'b1;
					push_beat.last     = 1'b1;
				end
			end
			ST_OFF_FLUSH: begin
				push           = pend_vld_q && can_push;
				push_beat.last = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_idx_q   <= '0;
			s1_vld_q   <= 1'b0;
			s1_idx_q   <= '0;
			found_q    <= 1'b0;
			pend_vld_q <= 1'b0;
			pend_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rd_idx_q   <= '0;
				s1_vld_q   <= 1'b0;
				found_q    <= 1'b0;
				pend_vld_q <= 1'b0;
			end
			if (advance) begin
				s1_vld_q <= issue;
				if (issue) begin
					s1_idx_q <= rd_idx_q[VOICE_W-1:0];
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				if (free_take) begin
					found_q <= 1'b1;
				end
				if (match) begin
					pend_vld_q <= 1'b1;
					pend_idx_q <= s1_idx_q;
				end
			end
			if ((state_q == ST_OFF_FLUSH) && can_push) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= evt.func;
			note_q <= evt.note_number;
			time_q <= evt.event_time;
			low_q  <= LOW_W'(LOW_INIT);
		end
		if (advance) begin
			if (free_take) begin
				best_q      <= tbl_rd_data.stamp;
				free_pick_q <= s1_idx_q;
			end
			if (steal_take) begin
				low_q        <= {1'b0, tbl_rd_data.note};
				steal_pick_q <= s1_idx_q;
			end
		end
	end

endmodule

// ===== design/poly_voice_allocator_core.sv =====
// polyphonic voice allocator, top level: sequencer, voice table, result register
// depends on pva_pkg, pva_ctrl and pva_table
//
// usage
//  - event channel (evt_valid / evt_stall / evt): one note-on or note-off per beat,
//    taken when evt_valid is high and evt_stall is low
//  - result channel (res_valid / res_stall / res): note-on gives one gate-1 beat
//    with pitch; note-off gives one gate-0 beat per released voice in ascending
//    voice order, last set on the final one, or no beat when nothing matches
//  - each event is one sweep over the voice table, a read per cycle from its
//    registered-read memories while no stalled result register halts the sweep
//  - evt_stall stays high for the whole sweep, so events enter one at a time:
//    the next event is taken only once the sequencer is back in idle
//  - a finished result waits in the output register while the next event is
//    taken; when the receiver stalls, the sweep halts on a second match until
//    the register frees, and results are never dropped or repeated
//  - reset clears the table at once through per-entry valid bits: every voice
//    free, note 0, release stamp 0; no clearing pass is needed
module poly_voice_allocator_core import pva_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      evt_valid,
	output logic      evt_stall,
	input  in_beat_t  evt,
	output logic      res_valid,
	input  logic      res_stall,
	output out_beat_t res
);

	logic               can_push;
	logic               push;
	out_beat_t          push_beat;
	logic               tbl_rd_en;
	logic [VOICE_W-1:0] tbl_rd_addr;
	logic [VOICE_W-1:0] tbl_wr_addr;
	tbl_wr_t            tbl_wr;
	tbl_entry_t         tbl_rd_data;

	logic          res_valid_q;
	out_beat_t     res_q;

	// sweep control and voice selection
	pva_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt_valid   (evt_valid),
		.evt_stall   (evt_stall),
		.evt         (evt),
		.can_push    (can_push),
		.push        (push),
		.push_beat   (push_beat),
		.tbl_rd_en   (tbl_rd_en),
		.tbl_rd_addr (tbl_rd_addr),
		.tbl_wr_addr (tbl_wr_addr),
		.tbl_wr      (tbl_wr),
		.tbl_rd_data (tbl_rd_data)
	);

	// voice state memories
	pva_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (tbl_rd_en),
		.rd_addr (tbl_rd_addr),
		.wr_addr (tbl_wr_addr),
		.wr      (tbl_wr),
		.rd_data (tbl_rd_data)
	);

	// output register: free now or emptied by the receiver this cycle
	assign can_push = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// payload only moves on a push, so a stalled beat holds
	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= push_beat;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== design/pva_checker.sv =====
// port-level checks for the voice allocator, bound to the top level
// depends on pva_pkg and poly_voice_allocator_core
module pva_port_checker import pva_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      evt_valid,
	input logic      evt_stall,
	input logic      res_valid,
	input logic      res_stall,
	input out_beat_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result beat changed");

	a_on_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.gate |-> res.last)
		else $error("note-on beat without last");

	a_off_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.gate |-> res.pitch_cv == '0)
		else $error("release beat with nonzero pitch");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_stall |=> evt_stall)
		else $error("event taken without sweep");

endmodule

bind poly_voice_allocator_core pva_port_checker u_pva_checker (.*);
